// ===== design/uaep_pkg.sv =====
// shared types and constants for the utf-8 / ansi escape byte parser
// no dependencies; imported by the controller, the datapath and the top level
package uaep_pkg;

  // result field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 21;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned AVAL_W  = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TDATA_W = 40;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_CODEPOINT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CONTROL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SAVE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTORE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CSI       = 3'd4;

  // parser modes
  localparam logic [1:0] MODE_GROUND = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // byte codes
  localparam logic [BYTE_W-1:0] BYTE_ESC    = 8'h1b;
  localparam logic [BYTE_W-1:0] BYTE_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] BYTE_SAVE   = 8'h37;
  localparam logic [BYTE_W-1:0] BYTE_REST   = 8'h38;
  localparam logic [BYTE_W-1:0] BYTE_SEMI   = 8'h3b;
  localparam logic [BYTE_W-1:0] BYTE_DIG0   = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_DIG9   = 8'h39;
  localparam logic [BYTE_W-1:0] BYTE_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_DEL    = 8'h7f;
  localparam logic [BYTE_W-1:0] BYTE_FIN_LO = 8'h40;
  localparam logic [BYTE_W-1:0] BYTE_FIN_HI = 8'h7e;
  localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hc2;
  localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hdf;
  localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hef;
  localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hf4;

  // codepoint limits
  localparam logic [VALUE_W-1:0] REPL_CP  = 21'h00fffd;
  localparam logic [VALUE_W-1:0] CP_MAX   = 21'h10ffff;
  localparam logic [VALUE_W-1:0] SURR_LO  = 21'h00d800;
  localparam logic [VALUE_W-1:0] SURR_HI  = 21'h00dfff;
  localparam logic [16:0]        MIN_2B   = 17'h00080;
  localparam logic [16:0]        MIN_3B   = 17'h00800;
  localparam logic [16:0]        MIN_4B   = 17'h10000;
  localparam logic [13:0]        ARG_CAP  = 14'd999;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the input word into the byte register
    logic step;       // commit the evaluated parser state
    logic load_eval;  // load the evaluated token into the output register
    logic load_arg;   // load the current csi parameter into the output register
    logic arg_start;  // restart the parameter counter
  } uaep_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;       // evaluated byte yields one token
    logic replay;     // token is a replacement, the byte must be evaluated again
    logic multi;      // csi final byte with parameters
    logic out_free;   // output register can take a word this cycle
    logic arg_last;   // counter points at the last parameter
  } uaep_sts_t;

endpackage

// ===== design/uaep_ctrl.sv =====
// sequencing state machine for the byte parser
// depends on uaep_pkg; drives commands into uaep_dpath and reads its status
module uaep_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uaep_pkg::uaep_sts_t sts_i,
  output uaep_pkg::uaep_cmd_t cmd_o
);
  import uaep_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_ARGS = 3'b100
  } uaep_state_e;

  uaep_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.replay) begin
          // replacement first, same byte again next cycle
          if (sts_i.out_free) begin
            cmd_o.load_eval = 1'b1;
            cmd_o.step      = 1'b1;
          end
        end else if (sts_i.multi) begin
          cmd_o.arg_start = 1'b1;
          state_d         = ST_ARGS;
        end else if (sts_i.emit) begin
          if (sts_i.out_free) begin
            cmd_o.load_eval = 1'b1;
            cmd_o.step      = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_ARGS: begin
        if (sts_i.out_free) begin
          cmd_o.load_arg = 1'b1;
          if (sts_i.arg_last) begin
            cmd_o.step = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/uaep_dpath.sv =====
// parser datapath: utf-8 decoder, escape/csi state, parameter store, output register
// depends on uaep_pkg; controlled by uaep_ctrl
module uaep_dpath #(
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [uaep_pkg::BYTE_W-1:0]     in_byte_i,
  input  uaep_pkg::uaep_cmd_t             cmd_i,
  output uaep_pkg::uaep_sts_t             sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [uaep_pkg::KIND_W-1:0]     token_kind_o,
  output logic [uaep_pkg::VALUE_W-1:0]    token_value_o,
  output logic [uaep_pkg::COUNT_W-1:0]    arg_count_o,
  output logic [uaep_pkg::INDEX_W-1:0]    arg_index_o,
  output logic [uaep_pkg::AVAL_W-1:0]     arg_value_o,
  output logic                            arg_present_o,
  output logic                            last_of_run_o
);
  import uaep_pkg::*;

  localparam int unsigned TW = $clog2(MAX_ARGS + 1);
  localparam int unsigned IW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

  // byte under evaluation
  logic [BYTE_W-1:0] byte_q;

  // parser and decoder state
  logic [1:0]         mode_q, mode_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [1:0]         left_q, left_d;
  logic [16:0]        min_q, min_d;
  logic [TW-1:0]      total_q, total_d;
  logic               ovf_q, ovf_d;
  logic [AVAL_W-1:0]  cur_val_q, cur_val_d;
  logic               cur_set_q, cur_set_d;

  // committed parameters, entries below total minus one
  logic [AVAL_W-1:0]  arg_val_q [MAX_ARGS];
  logic               arg_set_q [MAX_ARGS];
  logic               wr_en;
  logic [IW-1:0]      wr_idx;

  // parameter counter
  logic [IW-1:0]      idx_q;

  // evaluated token
  logic               ev_emit;
  logic               ev_replay;
  logic               ev_multi;
  logic               ev_last;
  logic [KIND_W-1:0]  ev_kind;
  logic [VALUE_W-1:0] ev_value;

  // output register
  logic               out_valid_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [INDEX_W-1:0] out_index_q;
  logic [AVAL_W-1:0]  out_aval_q;
  logic               out_pres_q;
  logic               out_last_q;

  // helpers
  logic [VALUE_W-1:0] acc_sh;
  logic               cp_bad;
  logic [13:0]        dig_base;
  logic [13:0]        dig_prod;
  logic [TW-1:0]      eff_total;
  logic [TW-1:0]      total_m1;
  logic [TW-1:0]      idx_ext;
  logic               rd_cur;
  logic [AVAL_W-1:0]  rd_val;
  logic               rd_set;
  logic [TW+3:0]      total_wide;
  logic [IW+3:0]      idx_wide;
  logic               out_free;
  logic               is_lead;

  assign acc_sh    = {acc_q[VALUE_W-7:0], byte_q[5:0]};
  assign cp_bad    = (acc_sh < VALUE_W'(min_q)) || (acc_sh > CP_MAX)
                   || ((acc_sh >= SURR_LO) && (acc_sh <= SURR_HI));
  assign dig_base  = cur_set_q ? 14'(cur_val_q) : 14'd0;
  assign dig_prod  = (dig_base << 3) + (dig_base << 1) + 14'(byte_q[3:0]);
  assign eff_total = (total_q == '0) ? TW'(1) : total_q;
  assign is_lead   = (byte_q >= LEAD2_LO) && (byte_q <= LEAD4_HI);

  // evaluate one byte against the current state
  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    left_d    = left_q;
    min_d     = min_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    cur_val_d = cur_val_q;
    cur_set_d = cur_set_q;
    wr_en     = 1'b0;
    wr_idx    = IW'(eff_total - TW'(1));
    ev_emit   = 1'b0;
    ev_replay = 1'b0;
    ev_multi  = 1'b0;
    ev_last   = 1'b1;
    ev_kind   = KIND_CODEPOINT;
    ev_value  = '0;
    case (mode_q)
      MODE_ESC: begin
        mode_d    = MODE_GROUND;
        total_d   = '0;
        ovf_d     = 1'b0;
        cur_val_d = '0;
        cur_set_d = 1'b0;
        if (byte_q == BYTE_LBRACK) begin
          mode_d = MODE_CSI;
          acc_d  = '0;
          left_d = '0;
          min_d  = '0;
        end else if (byte_q == BYTE_SAVE) begin
          ev_emit = 1'b1;
          ev_kind = KIND_SAVE;
        end else if (byte_q == BYTE_REST) begin
          ev_emit = 1'b1;
          ev_kind = KIND_RESTORE;
        end
      end
      MODE_CSI: begin
        if ((byte_q >= BYTE_DIG0) && (byte_q <= BYTE_DIG9)) begin
          // accumulate a decimal digit, capped
          if (total_q == '0) begin
            total_d = TW'(1);
          end
          cur_set_d = 1'b1;
          if (dig_prod > ARG_CAP) begin
            ovf_d     = 1'b1;
            cur_val_d = AVAL_W'(dig_base);
          end else begin
            cur_val_d = dig_prod[AVAL_W-1:0];
          end
        end else if (byte_q == BYTE_SEMI) begin
          // close the current parameter, open an unset one; with the list full, flag overflow instead
          total_d = eff_total;
          if (eff_total >= TW'(MAX_ARGS)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en     = 1'b1;
            cur_val_d = '0;
            cur_set_d = 1'b0;
            total_d   = eff_total + TW'(1);
          end
        end else begin
          mode_d    = MODE_GROUND;
          total_d   = '0;
          ovf_d     = 1'b0;
          cur_val_d = '0;
          cur_set_d = 1'b0;
          if ((byte_q >= BYTE_FIN_LO) && (byte_q <= BYTE_FIN_HI) && !ovf_q) begin
            if (total_q == '0) begin
              ev_emit  = 1'b1;
              ev_kind  = KIND_CSI;
              ev_value = VALUE_W'(byte_q);
            end else begin
              ev_multi = 1'b1;
            end
          end
        end
      end
      default: begin
        mode_d = MODE_GROUND;
        if (byte_q == BYTE_ESC) begin
          // partial utf-8 sequence is dropped
          acc_d  = '0;
          left_d = '0;
          min_d  = '0;
          mode_d = MODE_ESC;
        end else if ((left_q != '0) && (byte_q[7:6] != 2'b10)) begin
          // broken sequence: replacement, then the byte again from a clear decoder
          acc_d     = '0;
          left_d    = '0;
          min_d     = '0;
          ev_emit   = 1'b1;
          ev_replay = 1'b1;
          ev_value  = REPL_CP;
          ev_last   = is_lead;
        end else if (left_q != '0) begin
          if (left_q == 2'd1) begin
            acc_d    = '0;
            left_d   = '0;
            min_d    = '0;
            ev_emit  = 1'b1;
            ev_value = cp_bad ? REPL_CP : acc_sh;
          end else begin
            acc_d  = acc_sh;
            left_d = left_q - 2'd1;
          end
        end else if (byte_q < BYTE_SPACE) begin
          ev_emit  = 1'b1;
          ev_kind  = KIND_CONTROL;
          ev_value = VALUE_W'(byte_q);
        end else if (byte_q < BYTE_DEL) begin
          ev_emit  = 1'b1;
          ev_value = VALUE_W'(byte_q);
        end else if ((byte_q >= LEAD2_LO) && (byte_q <= LEAD2_HI)) begin
          acc_d  = VALUE_W'(byte_q[4:0]);
          min_d  = MIN_2B;
          left_d = 2'd1;
        end else if ((byte_q >= LEAD3_LO) && (byte_q <= LEAD3_HI)) begin
          acc_d  = VALUE_W'(byte_q[3:0]);
          min_d  = MIN_3B;
          left_d = 2'd2;
        end else if ((byte_q >= LEAD4_LO) && (byte_q <= LEAD4_HI)) begin
          acc_d  = VALUE_W'(byte_q[2:0]);
          min_d  = MIN_4B;
          left_d = 2'd3;
        end else begin
          ev_emit  = 1'b1;
          ev_value = REPL_CP;
        end
      end
    endcase
  end

  // parameter read at the counter; the newest one still sits in the open slot
  assign total_m1   = total_q - TW'(1);
  assign idx_ext    = TW'(idx_q);
  assign rd_cur     = (idx_ext == total_m1);
  assign rd_val     = rd_cur ? cur_val_q : arg_val_q[idx_q];
  assign rd_set     = rd_cur ? cur_set_q : arg_set_q[idx_q];
  assign total_wide = (TW + 4)'(total_q);
  assign idx_wide   = (IW + 4)'(idx_q);

  assign out_free = !out_valid_q || out_ready_i;

  // status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.emit     = ev_emit;
    sts_o.replay   = ev_replay;
    sts_o.multi    = ev_multi;
    sts_o.out_free = out_free;
    sts_o.arg_last = rd_cur;
  end

  // byte register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_GROUND;
      acc_q     <= '0;
      left_q    <= '0;
      min_q     <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      cur_val_q <= '0;
      cur_set_q <= 1'b0;
    end else if (cmd_i.step) begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      min_q     <= min_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
      cur_val_q <= cur_val_d;
      cur_set_q <= cur_set_d;
    end
  end

  // parameter store, written when a separator closes a parameter
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_en) begin
      arg_val_q[wr_idx] <= cur_val_q;
      arg_set_q[wr_idx] <= cur_set_q;
    end
  end

  // parameter counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.arg_start) begin
      idx_q <= '0;
    end else if (cmd_i.load_arg && !rd_cur) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_eval || cmd_i.load_arg) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_eval) begin
      out_kind_q  <= ev_kind;
      out_value_q <= ev_value;
      out_count_q <= '0;
      out_index_q <= '0;
      out_aval_q  <= '0;
      out_pres_q  <= 1'b0;
      out_last_q  <= ev_last;
    end else if (cmd_i.load_arg) begin
      out_kind_q  <= KIND_CSI;
      out_value_q <= VALUE_W'(byte_q);
      out_count_q <= total_wide[COUNT_W-1:0];
      out_index_q <= idx_wide[INDEX_W-1:0];
      out_aval_q  <= rd_set ? rd_val : '0;
      out_pres_q  <= rd_set;
      out_last_q  <= rd_cur;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = out_kind_q;
  assign token_value_o = out_value_q;
  assign arg_count_o   = out_count_q;
  assign arg_index_o   = out_index_q;
  assign arg_value_o   = out_aval_q;
  assign arg_present_o = out_pres_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== design/utf8_ansi_escape_byte_parser_unit.sv =====
// Console byte parser: UTF-8 decoding plus ESC / CSI sequence parsing.
// Depends on uaep_pkg, uaep_ctrl and uaep_dpath.
//
// Usage:
//   The slave stream takes one console byte per word. The master stream gives
//   tokens: codepoints, control bytes, cursor save/restore and CSI commands.
//   A CSI final byte gives one word per collected parameter; tlast marks the
//   last word caused by one input byte. Bytes that cause nothing give no word.
// Timing:
//   A byte is taken when s_axis_tready is high, which holds in the idle state
//   only. It is evaluated in the next cycle. A byte that breaks a UTF-8
//   sequence gives a replacement first and is then evaluated again; a CSI
//   final byte with N parameters gives N words, one per parameter, read from
//   the parameter store, the last one from the open slot.
// Reset and stall:
//   Reset puts the parser in ground state with an empty decoder and no
//   parameters, and empties the output register. A stalled master side holds
//   the current word; more bytes are taken and evaluated meanwhile, and the
//   block waits at the first byte that has a token to place.
module utf8_ansi_escape_byte_parser_unit #(
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [20:0] token_value, [24:21] arg_count,
                                      // [27:25] arg_index, [37:28] arg_value,
                                      // [38] arg_present, [39] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import uaep_pkg::*;

  uaep_cmd_t          cmd;
  uaep_sts_t          sts;
  logic [VALUE_W-1:0] token_value;
  logic [COUNT_W-1:0] arg_count;
  logic [INDEX_W-1:0] arg_index;
  logic [AVAL_W-1:0]  arg_value;
  logic               arg_present;

  // sequencing
  uaep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parser datapath
  uaep_dpath #(
    .MAX_ARGS (MAX_ARGS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .token_kind_o  (m_axis_tuser),
    .token_value_o (token_value),
    .arg_count_o   (arg_count),
    .arg_index_o   (arg_index),
    .arg_value_o   (arg_value),
    .arg_present_o (arg_present),
    .last_of_run_o (m_axis_tlast)
  );

  // pack the result word
  assign m_axis_tdata = {1'b0, arg_present, arg_value, arg_index, arg_count, token_value};

endmodule

// ===== test/tb_utf8_ansi_escape_byte_parser_unit.sv =====
// self-checking testbench for the utf-8 / ansi escape byte parser
// depends on uaep_pkg and utf8_ansi_escape_byte_parser_unit; predicts tokens per byte
// and compares every master-side word, under four phases of random idling and stalls
module tb_utf8_ansi_escape_byte_parser_unit;
  import uaep_pkg::*;

  localparam int NUM_ARGS       = 8;
  localparam int BYTES_PER_PHASE = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 16;

  // one expected master-side word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] idx;
    logic [AVAL_W-1:0]  aval;
    logic               pres;
    logic               last;
  } token_t;

  // one console byte waiting to be sent, with the idling of its phase
  typedef struct packed {
    logic [7:0] b;
    logic [6:0] idle_pct;
    logic [6:0] stall_pct;
    logic       hold;
  } con_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  con_byte_t   byte_q[$];
  token_t      token_q[$];
  token_t      run_q[$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  int          stall_pct = 0;

  // stimulus builder state
  int          cur_idle = 0;
  int          cur_stall = 0;
  bit          cur_hold = 1'b0;

  // predictor state
  logic [1:0]         parse_st;
  logic [VALUE_W-1:0] utf8_acc;
  logic [1:0]         utf8_left;
  logic [16:0]        utf8_min;
  int                 arg_val[NUM_ARGS];
  bit                 arg_set[NUM_ARGS];
  int                 arg_total;
  bit                 arg_ovf;

  utf8_ansi_escape_byte_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_utf8();
    utf8_acc  = '0;
    utf8_left = '0;
    utf8_min  = '0;
  endfunction

  function automatic void clear_csi();
    parse_st = MODE_GROUND;
    for (int i = 0; i < NUM_ARGS; i++) begin
      arg_val[i] = 0;
      arg_set[i] = 1'b0;
    end
    arg_total = 0;
    arg_ovf   = 1'b0;
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] kind,
                                    input logic [VALUE_W-1:0] value,
                                    input int count, input int idx,
                                    input int aval, input bit pres);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.count = count[COUNT_W-1:0];
    t.idx   = idx[INDEX_W-1:0];
    t.aval  = aval[AVAL_W-1:0];
    t.pres  = pres;
    t.last  = 1'b0;
    run_q.push_back(t);
  endfunction

  // ground mode: utf-8 decoding, controls and escape entry
  function automatic void ground_byte(input logic [7:0] b);
    logic [VALUE_W-1:0] cp;
    if (b == BYTE_ESC) begin
      clear_utf8();
      parse_st = MODE_ESC;
      return;
    end
    if (utf8_left != 0) begin
      if (b[7:6] != 2'b10) begin
        // broken sequence: replacement, then the byte counts again from ground
        add_token(KIND_CODEPOINT, REPL_CP, 0, 0, 0, 1'b0);
        clear_utf8();
      end else begin
        utf8_acc  = {utf8_acc[VALUE_W-7:0], b[5:0]};
        utf8_left = utf8_left - 2'd1;
        if (utf8_left != 0) return;
        cp = utf8_acc;
        if (cp < {4'd0, utf8_min} || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI))
          cp = REPL_CP;
        clear_utf8();
        add_token(KIND_CODEPOINT, cp, 0, 0, 0, 1'b0);
        return;
      end
    end
    if (b < BYTE_SPACE) begin
      add_token(KIND_CONTROL, {13'd0, b}, 0, 0, 0, 1'b0);
    end else if (b < BYTE_DEL) begin
      add_token(KIND_CODEPOINT, {13'd0, b}, 0, 0, 0, 1'b0);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      utf8_acc  = {16'd0, b[4:0]};
      utf8_min  = MIN_2B;
      utf8_left = 2'd1;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      utf8_acc  = {17'd0, b[3:0]};
      utf8_min  = MIN_3B;
      utf8_left = 2'd2;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      utf8_acc  = {18'd0, b[2:0]};
      utf8_min  = MIN_4B;
      utf8_left = 2'd3;
    end else begin
      add_token(KIND_CODEPOINT, REPL_CP, 0, 0, 0, 1'b0);
    end
  endfunction

  // csi mode: parameter digits, separators and the final byte
  function automatic void csi_byte(input logic [7:0] b);
    int d;
    int k;
    if (b >= BYTE_DIG0 && b <= BYTE_DIG9) begin
      d = int'(b - BYTE_DIG0);
      if (arg_total == 0) begin
        arg_total  = 1;
        arg_val[0] = 0;
        arg_set[0] = 1'b1;
      end
      k = arg_total - 1;
      if (!arg_set[k]) begin
        arg_set[k] = 1'b1;
        arg_val[k] = 0;
      end
      if (arg_val[k] > (int'(ARG_CAP) - d) / 10) arg_ovf = 1'b1;
      else arg_val[k] = arg_val[k] * 10 + d;
    end else if (b == BYTE_SEMI) begin
      if (arg_total == 0) begin
        arg_total  = 1;
        arg_val[0] = 0;
        arg_set[0] = 1'b0;
      end
      if (arg_total >= NUM_ARGS) begin
        arg_ovf = 1'b1;
      end else begin
        arg_val[arg_total] = 0;
        arg_set[arg_total] = 1'b0;
        arg_total++;
      end
    end else begin
      if (b >= BYTE_FIN_LO && b <= BYTE_FIN_HI && !arg_ovf) begin
        if (arg_total == 0) begin
          add_token(KIND_CSI, {13'd0, b}, 0, 0, 0, 1'b0);
        end else begin
          for (int i = 0; i < arg_total; i++)
            add_token(KIND_CSI, {13'd0, b}, arg_total, i,
                      arg_set[i] ? arg_val[i] : 0, arg_set[i]);
        end
      end
      clear_csi();
    end
  endfunction

  // work out the words caused by one accepted byte
  function automatic void predict_tokens(input logic [7:0] b);
    token_t t;
    run_q.delete();
    case (parse_st)
      MODE_ESC: begin
        if (b == BYTE_LBRACK) begin
          clear_csi();
          clear_utf8();
          parse_st = MODE_CSI;
        end else if (b == BYTE_SAVE) begin
          add_token(KIND_SAVE, '0, 0, 0, 0, 1'b0);
          clear_csi();
        end else if (b == BYTE_REST) begin
          add_token(KIND_RESTORE, '0, 0, 0, 0, 1'b0);
          clear_csi();
        end else begin
          clear_csi();
        end
      end
      MODE_CSI: csi_byte(b);
      default: begin
        parse_st = MODE_GROUND;
        ground_byte(b);
      end
    endcase
    for (int i = 0; i < run_q.size(); i++) begin
      t = run_q[i];
      t.last = (i == run_q.size() - 1);
      token_q.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    err_cnt++;
  endtask

  task automatic check_word();
    token_t want;
    if (token_q.size() == 0) begin
      report("word with nothing pending, token_value", 0, m_axis_tdata[20:0]);
      return;
    end
    want = token_q.pop_front();
    if (m_axis_tuser !== want.kind) report("token_kind", want.kind, m_axis_tuser);
    if (m_axis_tdata[20:0] !== want.value) report("token_value", want.value, m_axis_tdata[20:0]);
    if (m_axis_tdata[24:21] !== want.count) report("arg_count", want.count, m_axis_tdata[24:21]);
    if (m_axis_tdata[27:25] !== want.idx) report("arg_index", want.idx, m_axis_tdata[27:25]);
    if (m_axis_tdata[37:28] !== want.aval) report("arg_value", want.aval, m_axis_tdata[37:28]);
    if (m_axis_tdata[38] !== want.pres) report("arg_present", want.pres, m_axis_tdata[38]);
    if (m_axis_tdata[39] !== 1'b0) report("tdata pad bit", 0, m_axis_tdata[39]);
    if (m_axis_tlast !== want.last) report("last_of_run", want.last, m_axis_tlast);
  endtask

  // ---------------------------------------------------------------- stimulus builders

  function automatic void add_byte(input logic [7:0] b);
    con_byte_t c;
    c.b         = b;
    c.idle_pct  = cur_idle[6:0];
    c.stall_pct = cur_stall[6:0];
    c.hold      = cur_hold;
    cur_hold    = 1'b0;
    byte_q.push_back(c);
  endfunction

  function automatic void add_digits(input int ndig);
    for (int i = 0; i < ndig; i++) add_byte(BYTE_DIG0 + 8'($urandom_range(9)));
  endfunction

  // one random sequence, mostly well formed
  function automatic void add_sequence();
    int pick;
    int len;
    int nargs;
    pick = $urandom_range(99);
    if (pick < 20) begin
      add_byte(8'($urandom_range(127)));
    end else if (pick < 45) begin
      // multi-byte character, sometimes broken or cut short
      len = $urandom_range(2, 4);
      case (len)
        2: add_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
        3: add_byte(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
        default: add_byte(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
      endcase
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(14) == 0) add_byte(8'($urandom_range(255)));
        else add_byte(8'($urandom_range(8'h80, 8'hbf)));
      end
    end else if (pick < 55) begin
      add_byte(BYTE_ESC);
      case ($urandom_range(2))
        0: add_byte(BYTE_SAVE);
        1: add_byte(BYTE_REST);
        default: add_byte(8'($urandom_range(255)));
      endcase
    end else if (pick < 90) begin
      // csi command; nine parameters run past the list
      add_byte(BYTE_ESC);
      add_byte(BYTE_LBRACK);
      nargs = $urandom_range(9);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) add_byte(BYTE_SEMI);
        case ($urandom_range(5))
          0: ;
          1: add_digits(1);
          2: add_digits($urandom_range(2, 3));
          3: add_digits(4);
          4: begin
            add_byte(BYTE_DIG9);
            add_byte(BYTE_DIG9);
            add_byte(BYTE_DIG9);
          end
          default: add_digits($urandom_range(1, 2));
        endcase
      end
      if ($urandom_range(9) == 0) add_byte(8'($urandom_range(255)));
      add_byte(8'($urandom_range(BYTE_FIN_LO, BYTE_FIN_HI)));
    end else begin
      add_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_phase(input int idle, input int stall);
    int start;
    cur_idle  = idle;
    cur_stall = stall;
    cur_hold  = 1'b1;
    start     = byte_q.size();
    while (byte_q.size() - start < BYTES_PER_PHASE) add_sequence();
  endfunction

  // ---------------------------------------------------------------- byte driver

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    con_byte_t nxt;
    bit        fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        fire = 1'b0;
        if (byte_q.size() != 0) begin
          nxt = byte_q[0];
          // a held byte waits until every pending word has come out
          if (!(nxt.hold && token_q.size() != 0) &&
              $urandom_range(99) >= int'(nxt.idle_pct)) begin
            fire = 1'b1;
            void'(byte_q.pop_front());
            s_axis_tdata <= nxt.b;
            stall_pct    <= int'(nxt.stall_pct);
          end
        end
        s_axis_tvalid <= fire;
      end
    end
  end

  // ---------------------------------------------------------------- token monitor

  always @(posedge clk_i or negedge rst_ni) begin : token_monitor
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idle_cycles <= 0;
    else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- run control

  initial begin : run_ctrl
    parse_st = MODE_GROUND;
    clear_utf8();
    clear_csi();

    // directed: extremes, invalid leads, broken and valid sequences, escapes
    add_byte(8'h00);
    add_byte(8'h41);
    add_byte(BYTE_DEL);
    add_byte(8'h80);                  // stray continuation
    add_byte(8'hc1);                  // overlong lead
    add_byte(8'hff);
    add_byte(8'hc3);                  // non-continuation inside a sequence
    add_byte(8'h41);
    add_byte(8'he2);                  // escape drops the partial sequence
    add_byte(BYTE_ESC);
    add_byte(BYTE_SAVE);
    add_byte(BYTE_ESC);
    add_byte(BYTE_REST);
    add_byte(BYTE_ESC);               // unknown byte after escape
    add_byte(8'h5a);
    add_byte(8'hf0);                  // valid four-byte character
    add_byte(8'h9f);
    add_byte(8'h98);
    add_byte(8'h80);
    add_byte(BYTE_ESC);               // parameter above the cap, final gives nothing
    add_byte(BYTE_LBRACK);
    add_byte(BYTE_DIG0 + 8'd1);
    add_byte(BYTE_DIG0);
    add_byte(BYTE_DIG0);
    add_byte(BYTE_DIG0);
    add_byte(8'h6d);
    add_byte(BYTE_ESC);               // separator with the list full
    add_byte(BYTE_LBRACK);
    for (int i = 0; i < NUM_ARGS; i++) add_byte(BYTE_SEMI);
    add_byte(8'h48);
    add_byte(BYTE_ESC);               // intermediate byte drops the command
    add_byte(BYTE_LBRACK);
    add_byte(BYTE_SPACE);
    add_byte(BYTE_ESC);               // nine-nine-nine in the last of eight slots
    add_byte(BYTE_LBRACK);
    for (int i = 1; i < NUM_ARGS; i++) add_byte(BYTE_SEMI);
    add_byte(BYTE_DIG9);
    add_byte(BYTE_DIG9);
    add_byte(BYTE_DIG9);
    add_byte(BYTE_FIN_HI);

    // random phases: no idling, sender idle, receiver stall, both
    add_phase(0, 0);
    add_phase(64, 0);
    add_phase(0, 64);
    add_phase(33, 33);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
design/uaep_pkg.sv
design/uaep_ctrl.sv
design/uaep_dpath.sv
design/utf8_ansi_escape_byte_parser_unit.sv
test/tb_utf8_ansi_escape_byte_parser_unit.sv
